[hdl/lkvc_pkg.sv]
package lkvc_pkg;

	// Payload widths
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	// Capacity register value after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Value returned by a get that misses
	localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// Request codes carried on the input tuser
	typedef enum logic [1:0] {
		FUNC_PUT  = 2'd0,
		FUNC_GET  = 2'd1,
		FUNC_HEAD = 2'd2
	} func_t;

	// Update command broadcast to every entry cell
	typedef struct packed {
		logic en;        // apply an update this cycle
		logic insert;    // selected cell becomes valid
		logic age_all;   // every valid unselected cell ages by one
		logic touch;     // unselected cells more recent than ref_rank age by one
		logic wr_key;    // selected cell loads the request key
		logic wr_value;  // selected cell loads the request value
	} cell_cmd_t;

endpackage

[hdl/lkvc_cell.sv]
module lkvc_cell #(
	parameter int RANK_W = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkvc_pkg::cell_cmd_t        cmd,
	input  logic                       sel,
	input  logic [lkvc_pkg::DATA_W-1:0] req_key,
	input  logic [lkvc_pkg::DATA_W-1:0] req_value,
	input  logic [RANK_W-1:0]          ref_rank,
	input  logic [RANK_W-1:0]          lru_rank,
	output logic                       hit,
	output logic                       is_lru,
	output logic                       is_head,
	output logic                       is_free,
	output logic [RANK_W-1:0]          rank,
	output logic [lkvc_pkg::DATA_W-1:0] key,
	output logic [lkvc_pkg::DATA_W-1:0] value
);
	import lkvc_pkg::*;

	logic              valid_q;
	logic [RANK_W-1:0] rank_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] value_q;

	// Match and status flags
	assign hit     = valid_q && (key_q == req_key);
	assign is_lru  = valid_q && (rank_q == lru_rank);
	assign is_head = valid_q && (rank_q == '0);
	assign is_free = !valid_q;
	assign rank    = rank_q;
	assign key     = key_q;
	assign value   = value_q;

	// Valid mark and recency rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.en) begin
			if (sel) begin
				rank_q <= '0;
				if (cmd.insert) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && (cmd.age_all || (cmd.touch && (rank_q < ref_rank)))) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	// Stored key and value
	always_ff @(posedge clk) begin
		if (cmd.en && sel) begin
			if (cmd.wr_key) begin
				key_q <= req_key;
			end
			if (cmd.wr_value) begin
				value_q <= req_value;
			end
		end
	end

endmodule

[hdl/lru_key_value_cache.sv]
// Fully associative key-value store with least-recently-used replacement.
//
// Input stream (s_axis): tuser carries the request code (put, get, head),
// tdata carries key and value. Output stream (m_axis): one result
// transaction per request, with found and head_valid on tuser and
// read_value, head_key, head_value on tdata.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the capacity;
// it is always ready. Write it only while no request is in flight.
//
// A request is registered in the input register on acceptance; all entries
// are then compared, their ranks updated and the result registered in the
// output register once that register is free. One request per cycle is
// sustained while the receiver does not stall: the key compare and rank
// update of every entry cell happen in parallel.
// When the receiver stalls, the result stays in the output register and the
// input register holds one more request; s_axis_tready then drops.
// Reset clears all valid marks, ranks, the entry count and both stream
// registers, and sets the capacity to 16.
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [2*lkvc_pkg::DATA_W-1:0] s_axis_tdata,  // key, value
	input  logic [1:0]                    s_axis_tuser,  // func
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [3*lkvc_pkg::DATA_W-1:0] m_axis_tdata,  // read_value, head_key, head_value
	output logic [1:0]                    m_axis_tuser,  // found, head_valid
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data       // capacity
);
	import lkvc_pkg::*;

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Capacity register
	logic [CAP_W-1:0] cap_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// Input register
	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [DATA_W-1:0] key_s1;
	logic [DATA_W-1:0] value_s1;
	logic              go;

	assign go            = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1  <= s_axis_tuser;
			key_s1   <= s_axis_tdata[DATA_W-1:0];
			value_s1 <= s_axis_tdata[2*DATA_W-1:DATA_W];
		end
	end

	// Entry cells
	cell_cmd_t         cmd;
	logic [ENTRIES-1:0] sel_vec;
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] lru_vec;
	logic [ENTRIES-1:0] head_vec;
	logic [ENTRIES-1:0] free_vec;
	logic [RANK_W-1:0]  cell_rank  [ENTRIES];
	logic [DATA_W-1:0]  cell_key   [ENTRIES];
	logic [DATA_W-1:0]  cell_value [ENTRIES];
	logic [RANK_W-1:0]  ref_rank;
	logic [RANK_W-1:0]  lru_rank;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkvc_cell #(
			.RANK_W (RANK_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.sel       (sel_vec[g]),
			.req_key   (key_s1),
			.req_value (value_s1),
			.ref_rank  (ref_rank),
			.lru_rank  (lru_rank),
			.hit       (hit_vec[g]),
			.is_lru    (lru_vec[g]),
			.is_head   (head_vec[g]),
			.is_free   (free_vec[g]),
			.rank      (cell_rank[g]),
			.key       (cell_key[g]),
			.value     (cell_value[g])
		);
	end

	// Entry count and derived ranks
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_m1;
	logic [CMP_W-1:0] eff_cap;
	logic             has_room;

	assign count_m1 = count_q - CNT_W'(1);
	assign lru_rank = count_m1[RANK_W-1:0];

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end

	assign has_room = CMP_W'(count_q) < eff_cap;

	// One-hot selection of hit entry, current head, first free slot
	logic [RANK_W-1:0]  hit_rank;
	logic [DATA_W-1:0]  hit_key;
	logic [DATA_W-1:0]  hit_value;
	logic [DATA_W-1:0]  cur_head_key;
	logic [DATA_W-1:0]  cur_head_value;
	logic               any_hit;
	logic [ENTRIES-1:0] free_first;

	assign any_hit    = |hit_vec;
	assign free_first = free_vec & (~free_vec + ENTRIES'(1));

	always_comb begin
		hit_rank       = '0;
		hit_key        = '0;
		hit_value      = '0;
		cur_head_key   = '0;
		cur_head_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_vec[i]) begin
				hit_rank  = hit_rank | cell_rank[i];
				hit_key   = hit_key | cell_key[i];
				hit_value = hit_value | cell_value[i];
			end
			if (head_vec[i]) begin
				cur_head_key   = cur_head_key | cell_key[i];
				cur_head_value = cur_head_value | cell_value[i];
			end
		end
	end

	// Request decode and update command
	logic              found_d;
	logic [DATA_W-1:0] rv_d;
	logic              head_valid_d;
	logic [DATA_W-1:0] head_key_d;
	logic [DATA_W-1:0] head_value_d;

	always_comb begin
		cmd          = '0;
		sel_vec      = '0;
		ref_rank     = '0;
		count_d      = count_q;
		found_d      = 1'b0;
		rv_d         = '0;
		head_valid_d = (count_q != '0);
		head_key_d   = cur_head_key;
		head_value_d = cur_head_value;
		unique case (func_s1)
			FUNC_PUT: begin
				cmd.en       = go;
				cmd.wr_value = 1'b1;
				rv_d         = value_s1;
				head_valid_d = 1'b1;
				head_key_d   = key_s1;
				head_value_d = value_s1;
				if (any_hit) begin
					found_d   = 1'b1;
					sel_vec   = hit_vec;
					cmd.touch = 1'b1;
					ref_rank  = hit_rank;
				end else if (has_room) begin
					sel_vec     = free_first;
					cmd.insert  = 1'b1;
					cmd.age_all = 1'b1;
					cmd.wr_key  = 1'b1;
					count_d     = count_q + CNT_W'(1);
				end else begin
					// evict least recent and reuse its slot
					sel_vec    = lru_vec;
					cmd.touch  = 1'b1;
					cmd.wr_key = 1'b1;
					ref_rank   = lru_rank;
				end
			end
			FUNC_GET: begin
				if (any_hit) begin
					cmd.en       = go;
					cmd.touch    = 1'b1;
					sel_vec      = hit_vec;
					ref_rank     = hit_rank;
					found_d      = 1'b1;
					rv_d         = hit_value;
					head_valid_d = 1'b1;
					head_key_d   = hit_key;
					head_value_d = hit_value;
				end else begin
					rv_d = MISS_VALUE;
				end
			end
			default: begin
				// head request and unused code read the current head
			end
		endcase
		if (!head_valid_d) begin
			head_key_d   = '0;
			head_value_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (go) begin
			count_q <= count_d;
		end
	end

	// Output register
	logic              m_valid_s2;
	logic              found_s2;
	logic              head_valid_s2;
	logic [DATA_W-1:0] rv_s2;
	logic [DATA_W-1:0] head_key_s2;
	logic [DATA_W-1:0] head_value_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s2 <= 1'b0;
		end else if (go) begin
			m_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			found_s2      <= found_d;
			head_valid_s2 <= head_valid_d;
			rv_s2         <= rv_d;
			head_key_s2   <= head_key_d;
			head_value_s2 <= head_value_d;
		end
	end

	assign m_axis_tvalid = m_valid_s2;
	assign m_axis_tuser  = {head_valid_s2, found_s2};
	assign m_axis_tdata  = {head_value_s2, head_key_s2, rv_s2};

	// Checks
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(~free_vec) == int'(count_q))
		else $error("entry count differs from number of valid entries");

	a_single_head: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(head_vec) == ((count_q != '0) ? 1 : 0))
		else $error("most recent entry not unique");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key held in more than one entry");

	a_single_lru: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> $onehot(lru_vec))
		else $error("least recent entry not unique");

endmodule

[tb/lru_key_value_cache_tb.sv]
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
	import lkvc_pkg::*;

	localparam int ENTRIES = 16;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 66;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 64;
	localparam int HOLD_AT = 200;
	localparam int STEADY_FROM = 300;
	localparam int STEADY_TO = 400;
	// Spare request code, decoded by the block as a head read
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic        found;
		logic [31:0] read_value;
		logic        head_valid;
		logic [31:0] head_key;
		logic [31:0] head_value;
	} result_t;

	typedef struct packed {
		logic              is_cfg;
		logic [CAP_W-1:0]  cap;
		logic [1:0]        func;
		logic [31:0]       key;
		logic [31:0]       value;
		logic              typed;
		result_t           res;
	} step_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [2*DATA_W-1:0] s_axis_tdata;
	logic [1:0]          s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [3*DATA_W-1:0] m_axis_tdata;
	logic [1:0]          m_axis_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_W-1:0]    cfg_data;

	// Shadow copy of the cache contents
	logic [31:0]      shadow_key [ENTRIES];
	logic [31:0]      shadow_value [ENTRIES];
	bit               shadow_valid [ENTRIES];
	int               shadow_rank [ENTRIES];
	int               shadow_count;
	logic [CAP_W-1:0] shadow_cap;

	result_t pending_results [$];
	step_t   dir_steps [24];
	logic [31:0] key_pool [32];

	int n_sent, n_received, n_errors, n_hits, n_misses, n_evictions, n_cfg;
	bit steady;

	assign steady = (n_sent >= STEADY_FROM) && (n_sent < STEADY_TO);

	lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // key, value
		.s_axis_tuser  (s_axis_tuser),   // func
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // read_value, head_key, head_value
		.m_axis_tuser  (m_axis_tuser),   // found, head_valid
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)        // capacity
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Make slot s most recent; entries more recent than it age by one
	function automatic void promote(int s);
		for (int i = 0; i < ENTRIES; i++) begin
			if (shadow_valid[i] && i != s && shadow_rank[i] < shadow_rank[s])
				shadow_rank[i]++;
		end
		shadow_rank[s] = 0;
	endfunction

	// Apply one request to the shadow cache and return its result
	function automatic result_t cache_request(logic [1:0] func, logic [31:0] key,
			logic [31:0] value);
		result_t res;
		int hit, slot, cap_eff;
		res = '0;
		hit = -1;
		cap_eff = (shadow_cap == 0) ? 1 : (shadow_cap > ENTRIES) ? ENTRIES : shadow_cap;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (shadow_valid[i] && shadow_key[i] == key)
				hit = i;
		end
		case (func)
		FUNC_PUT: begin
			res.read_value = value;
			if (hit >= 0) begin
				res.found = 1'b1;
				shadow_value[hit] = value;
				promote(hit);
				n_hits++;
			end else begin
				n_misses++;
				slot = -1;
				if (shadow_count < cap_eff) begin
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!shadow_valid[i])
							slot = i;
				end
				if (slot >= 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (shadow_valid[i])
							shadow_rank[i]++;
					shadow_valid[slot] = 1'b1;
					shadow_rank[slot] = 0;
					shadow_count++;
				end else begin
					// evict the least recent entry, reuse its slot
					for (int i = 0; i < ENTRIES; i++)
						if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot]))
							slot = i;
					if (slot >= 0) begin
						promote(slot);
						n_evictions++;
					end
				end
				if (slot >= 0) begin
					shadow_key[slot] = key;
					shadow_value[slot] = value;
				end
			end
		end
		FUNC_GET: begin
			if (hit >= 0) begin
				res.found = 1'b1;
				res.read_value = shadow_value[hit];
				promote(hit);
				n_hits++;
			end else begin
				res.read_value = MISS_VALUE;
				n_misses++;
			end
		end
		default: ;
		endcase
		// most recent entry after the update
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (shadow_valid[i] && shadow_rank[i] == 0) begin
				res.head_valid = 1'b1;
				res.head_key = shadow_key[i];
				res.head_value = shadow_value[i];
			end
		end
		return res;
	endfunction

	// Offer one request, wait for the transaction, then record its expected result
	task automatic send_request(logic [1:0] func, logic [31:0] key, logic [31:0] value,
			bit typed, result_t typed_res);
		result_t res;
		while (!steady && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {value, key};
		s_axis_tuser <= func;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		res = cache_request(func, key, value);
		pending_results.push_back(typed ? typed_res : res);
		n_sent++;
	endtask

	// Drain outstanding results, then write the capacity register
	task automatic write_capacity(logic [CAP_W-1:0] cap);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shadow_cap = cap;
		n_cfg++;
	endtask

	task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, expected, actual);
			n_errors++;
		end
	endtask

	// Output receiver: random back-pressure, one long hold-off, then a steady window
	initial begin
		bit held;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && n_sent >= HOLD_AT) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= steady || ($urandom_range(99) >= 20);
		end
	end

	// Result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_received++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h %h", $time,
					m_axis_tuser, m_axis_tdata);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("found", want.found, m_axis_tuser[0]);
				check_field("read_value", want.read_value, m_axis_tdata[31:0]);
				check_field("head_valid", want.head_valid, m_axis_tuser[1]);
				check_field("head_key", want.head_key, m_axis_tdata[63:32]);
				check_field("head_value", want.head_value, m_axis_tdata[95:64]);
			end
		end
	end

	// Watchdog: ends the run after too many cycles without any transaction
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Stimulus
	initial begin
		int r, pool_n, cap_eff;
		logic [1:0] func;
		logic [31:0] key;
		logic [CAP_W-1:0] phase_caps [RAND_PHASES];

		phase_caps = '{5'd1, 5'd5, 5'd0, 5'd31, 5'd3, 5'd16, 5'd2, 5'd12};
		dir_steps = '{
			// empty store: head and a get miss
			'{1'b0, 5'd0, FUNC_HEAD, 32'h0, 32'h0, 1'b1,
				'{1'b0, 32'h0, 1'b0, 32'h0, 32'h0}},
			'{1'b0, 5'd0, FUNC_GET, 32'h0, 32'h0, 1'b1,
				'{1'b0, MISS_VALUE, 1'b0, 32'h0, 32'h0}},
			// extreme keys and values
			'{1'b0, 5'd0, FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
				'{1'b0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF}},
			'{1'b0, 5'd0, FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
				'{1'b0, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000}},
			'{1'b0, 5'd0, FUNC_GET, 32'h8000_0000, 32'h0, 1'b1,
				'{1'b1, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF}},
			// put on a held key overwrites
			'{1'b0, 5'd0, FUNC_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
				'{1'b1, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF}},
			'{1'b0, 5'd0, FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
			// spare code reads like head
			'{1'b0, 5'd0, FUNC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_HEAD, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_PUT, 32'h0, 32'h0, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_PUT, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
			// capacity lowered below the count
			'{1'b1, 5'd2, FUNC_PUT, 32'h0, 32'h0, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_PUT, 32'h1, 32'd10, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_PUT, 32'h2, 32'd20, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_GET, 32'h0, 32'h0, 1'b0, '0},
			// zero capacity acts as one
			'{1'b1, 5'd0, FUNC_PUT, 32'h0, 32'h0, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_PUT, 32'h3, 32'd30, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_GET, 32'h2, 32'h0, 1'b0, '0},
			// capacity above the entry count is clipped
			'{1'b1, 5'd31, FUNC_PUT, 32'h0, 32'h0, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_PUT, 32'h4, 32'd40, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_GET, 32'h3, 32'h0, 1'b0, '0},
			'{1'b1, 5'd16, FUNC_PUT, 32'h0, 32'h0, 1'b0, '0},
			'{1'b0, 5'd0, FUNC_GET, 32'h4, 32'h0, 1'b0, '0}
		};

		// shadow reset state
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_key[i] = '0;
			shadow_value[i] = '0;
			shadow_valid[i] = 1'b0;
			shadow_rank[i] = 0;
		end
		shadow_count = 0;
		shadow_cap = CAP_RESET;
		n_sent = 0;
		n_received = 0;
		n_errors = 0;
		n_hits = 0;
		n_misses = 0;
		n_evictions = 0;
		n_cfg = 0;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= FUNC_HEAD;
		cfg_valid <= 1'b0;
		cfg_data <= CAP_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_steps[i]) begin
			if (dir_steps[i].is_cfg)
				write_capacity(dir_steps[i].cap);
			else
				send_request(dir_steps[i].func, dir_steps[i].key, dir_steps[i].value,
					dir_steps[i].typed, dir_steps[i].res);
		end

		// random phases, one capacity each; keys mostly from a pool a bit
		// larger than the capacity so hits, misses and evictions all occur
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_capacity(phase_caps[p]);
			cap_eff = (phase_caps[p] == 0) ? 1 :
				(phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p];
			pool_n = cap_eff + $urandom_range(1, 6);
			for (int i = 0; i < pool_n; i++)
				key_pool[i] = $urandom();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				func = (r < 45) ? FUNC_PUT : (r < 80) ? FUNC_GET : (r < 95) ? FUNC_HEAD :
					FUNC_SPARE;
				key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)] :
					$urandom();
				send_request(func, key, $urandom(), 1'b0, '0);
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain and let the pipeline settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			n_errors++;
		end

		$display("Ran %0d requests over %0d capacity writes: %0d hits, %0d misses, %0d evictions",
			n_sent, n_cfg, n_hits, n_misses, n_evictions);
		$display("Results checked: %0d, errors: %0d", n_received, n_errors);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
